>>> hdl/kmde_pkg.sv
// ---------------------------------------------------------------------------
// kmde_pkg: shared types and constants for the key matrix debouncer
// Column lane layout, history codes, event kinds and the serializer job.
// ---------------------------------------------------------------------------
package kmde_pkg;

    // Matrix geometry
    localparam int NUM_ROWS    = 8;
    localparam int NUM_COLUMNS = 8;
    localparam int LEVEL_BITS  = 8;
    localparam int LANE_COUNT  = (NUM_COLUMNS < LEVEL_BITS) ? NUM_COLUMNS : LEVEL_BITS;

    // Field widths
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 2;
    localparam int HIST_W  = 6;
    localparam int ROW_SLOTS = 1 << ROW_W;

    // History codes
    localparam logic [HIST_W-1:0]  HIST_PRESS   = 6'b011111;
    localparam logic [HIST_W-1:0]  HIST_RELEASE = 6'b100000;
    localparam logic [COUNT_W-1:0] TALLY_MAX    = 7'd127;

    // Bus widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESS         = 2'd0,
        EV_RELEASE       = 2'd1,
        EV_PRESS_COUNT   = 2'd2,
        EV_RELEASE_COUNT = 2'd3
    } event_kind_t;

    typedef logic [HIST_W-1:0] hist_t;

    // Per-lane detection flags
    typedef struct packed {
        logic press;
        logic release_ev;
    } lane_flags_t;

    // Work handed to the serializer for one item
    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [LANE_COUNT-1:0] press_mask;
        logic [LANE_COUNT-1:0] release_mask;
        logic                  press_cnt_valid;
        logic [COUNT_W-1:0]    press_cnt;
        logic                  release_cnt_valid;
        logic [COUNT_W-1:0]    release_cnt;
    } job_t;

    // Number of set bits in a lane mask
    function automatic logic [COL_W:0] popcount(input logic [LANE_COUNT-1:0] mask);
        logic [COL_W:0] acc;
        acc = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            acc = acc + (COL_W + 1)'(mask[i]);
        end
        return acc;
    endfunction

    // Add and clamp at TALLY_MAX
    function automatic logic [COUNT_W-1:0] tally_add(input logic [COUNT_W-1:0] tally,
                                                     input logic [COL_W:0]     inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, tally} + (COUNT_W + 1)'(inc);
        return (sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : sum[COUNT_W-1:0];
    endfunction

endpackage

>>> hdl/kmde_lane.sv
// ---------------------------------------------------------------------------
// kmde_lane: one column of the debouncer
// Shifts the pressed level into the key history and flags press and
// release patterns.
// ---------------------------------------------------------------------------
module kmde_lane (
    input  kmde_pkg::hist_t       hist_old,
    input  logic                  level,      // raw pin, low = pressed
    output kmde_pkg::hist_t       hist_new,
    output kmde_pkg::lane_flags_t flags
);

    // Shift in the inverted pin level
    assign hist_new = {hist_old[kmde_pkg::HIST_W-2:0], ~level};

    // Pattern match
    assign flags.press      = (hist_new == kmde_pkg::HIST_PRESS);
    assign flags.release_ev = (hist_new == kmde_pkg::HIST_RELEASE);

endmodule

>>> hdl/kmde_merge.sv
// ---------------------------------------------------------------------------
// kmde_merge: event serializer
// Holds one item's lane results and emits them one per cycle unless stalled
// by m_tready, key events in column order, then count events, via an output register.
// ---------------------------------------------------------------------------
module kmde_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kmde_pkg::job_t       job_in,
    input  logic                 load,
    output logic                 load_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [kmde_pkg::M_DATA_W-1:0] m_tdata,  // key_row, key_column, key_count, pad
    output logic [kmde_pkg::KIND_W-1:0]   m_tuser,  // event_kind
    output logic                 m_tlast            // run_last
);

    kmde_pkg::job_t job_reg, job_cleared;
    logic           busy_reg;

    logic                            m_valid_reg;
    logic [kmde_pkg::ROW_W-1:0]      out_row_reg;
    logic [kmde_pkg::COL_W-1:0]      out_col_reg;
    logic [kmde_pkg::COUNT_W-1:0]    out_count_reg;
    kmde_pkg::event_kind_t           out_kind_reg;
    logic                            out_last_reg;

    logic [kmde_pkg::LANE_COUNT-1:0] ev_mask;
    logic                            any_key;
    logic [kmde_pkg::COL_W-1:0]      sel_col;
    kmde_pkg::event_kind_t           sel_kind;
    logic [kmde_pkg::COUNT_W-1:0]    sel_count;
    logic                            remaining;
    logic                            emit_fire;
    logic                            job_any;

    // Lowest pending column
    assign ev_mask = job_reg.press_mask | job_reg.release_mask;
    assign any_key = |ev_mask;

    always_comb begin
        sel_col = '0;
        for (int i = kmde_pkg::LANE_COUNT - 1; i >= 0; i--) begin
            if (ev_mask[i]) begin
                sel_col = kmde_pkg::COL_W'(i);
            end
        end
    end

    // Pick the event and clear it from the job
    always_comb begin
        job_cleared = job_reg;
        sel_count   = '0;
        if (any_key) begin
            sel_kind = job_reg.press_mask[sel_col] ? kmde_pkg::EV_PRESS
                                                   : kmde_pkg::EV_RELEASE;
            job_cleared.press_mask[sel_col]   = 1'b0;
            job_cleared.release_mask[sel_col] = 1'b0;
        end else if (job_reg.press_cnt_valid) begin
            sel_kind  = kmde_pkg::EV_PRESS_COUNT;
            sel_count = job_reg.press_cnt;
            job_cleared.press_cnt_valid = 1'b0;
        end else begin
            sel_kind  = kmde_pkg::EV_RELEASE_COUNT;
            sel_count = job_reg.release_cnt;
            job_cleared.release_cnt_valid = 1'b0;
        end
        remaining = (|job_cleared.press_mask) | (|job_cleared.release_mask)
                  | job_cleared.press_cnt_valid | job_cleared.release_cnt_valid;
    end

    assign emit_fire  = busy_reg && (!m_valid_reg || m_tready);
    assign load_ready = !busy_reg || (emit_fire && !remaining);
    assign job_any    = (|job_in.press_mask) | (|job_in.release_mask)
                      | job_in.press_cnt_valid | job_in.release_cnt_valid;

    // Job register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= job_any;
        end else if (emit_fire) begin
            busy_reg <= remaining;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_in;
        end else if (emit_fire) begin
            job_reg <= job_cleared;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            out_kind_reg  <= sel_kind;
            out_row_reg   <= any_key ? job_reg.row : '0;
            out_col_reg   <= any_key ? sel_col : '0;
            out_count_reg <= sel_count;
            out_last_reg  <= !remaining;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = kmde_pkg::M_DATA_W'({out_count_reg, out_col_reg, out_row_reg});
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/key_matrix_debounce_events.sv
// ---------------------------------------------------------------------------
// key_matrix_debounce_events: key matrix debouncer with press/release events
// Path: an item's first result passes the job register, then the output register.
// Throughput: one result per cycle unless m_tready stalls; a new item is accepted
// only as kmde_merge emits the last result of the previous one (up to ten per item).
// Reset: aresetn synchronous active low; all key histories cleared to
// released, tallies zeroed, no pending results.
// ---------------------------------------------------------------------------
module key_matrix_debounce_events (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [kmde_pkg::S_DATA_W-1:0] s_tdata,  // row_index, column_levels, pad
    input  logic        s_tlast,                    // scan_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [kmde_pkg::M_DATA_W-1:0] m_tdata,  // key_row, key_column, key_count, pad
    output logic [kmde_pkg::KIND_W-1:0]   m_tuser,  // event_kind
    output logic        m_tlast                     // run_last
);

    logic [kmde_pkg::LANE_COUNT-1:0][kmde_pkg::HIST_W-1:0] history_reg [kmde_pkg::ROW_SLOTS];
    logic [kmde_pkg::COUNT_W-1:0] pressed_tally_reg, pressed_tally_next;
    logic [kmde_pkg::COUNT_W-1:0] released_tally_reg, released_tally_next;

    logic [kmde_pkg::ROW_W-1:0]      row_index;
    logic [kmde_pkg::LEVEL_BITS-1:0] column_levels;
    logic                            accept;
    logic                            row_ok;
    logic                            load_ready;

    kmde_pkg::hist_t       hist_old [kmde_pkg::LANE_COUNT];
    kmde_pkg::hist_t       hist_new [kmde_pkg::LANE_COUNT];
    kmde_pkg::lane_flags_t flags    [kmde_pkg::LANE_COUNT];
    logic [kmde_pkg::LANE_COUNT-1:0] press_mask, release_mask;
    kmde_pkg::job_t        job;

    assign row_index     = s_tdata[kmde_pkg::ROW_W-1:0];
    assign column_levels = s_tdata[kmde_pkg::ROW_W +: kmde_pkg::LEVEL_BITS];
    assign accept        = s_tvalid && load_ready;
    assign s_tready      = load_ready;
    assign row_ok        = (32'(row_index) < kmde_pkg::NUM_ROWS);

    // Column lanes
    for (genvar g = 0; g < kmde_pkg::LANE_COUNT; g++) begin : g_lane
        assign hist_old[g] = history_reg[row_index][g];
        kmde_lane u_lane (
            .hist_old (hist_old[g]),
            .level    (column_levels[g]),
            .hist_new (hist_new[g]),
            .flags    (flags[g])
        );
        assign press_mask[g]   = row_ok && flags[g].press;
        assign release_mask[g] = row_ok && flags[g].release_ev;
    end

    // History store write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < kmde_pkg::ROW_SLOTS; r++) begin
                history_reg[r] <= '0;
            end
        end else if (accept && row_ok) begin
            for (int c = 0; c < kmde_pkg::LANE_COUNT; c++) begin
                history_reg[row_index][c] <= hist_new[c];
            end
        end
    end

    // Per-scan tallies and job assembly
    always_comb begin
        pressed_tally_next  = kmde_pkg::tally_add(pressed_tally_reg,
                                                  kmde_pkg::popcount(press_mask));
        released_tally_next = kmde_pkg::tally_add(released_tally_reg,
                                                  kmde_pkg::popcount(release_mask));
        job.row               = row_index;
        job.press_mask        = press_mask;
        job.release_mask      = release_mask;
        job.press_cnt         = pressed_tally_next;
        job.release_cnt       = released_tally_next;
        job.press_cnt_valid   = s_tlast && (pressed_tally_next != '0);
        job.release_cnt_valid = s_tlast && (released_tally_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_tally_reg  <= '0;
            released_tally_reg <= '0;
        end else if (accept) begin
            pressed_tally_reg  <= s_tlast ? '0 : pressed_tally_next;
            released_tally_reg <= s_tlast ? '0 : released_tally_next;
        end
    end

    // Event serializer
    kmde_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_in     (job),
        .load       (accept),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
